// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the tag store RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SCAM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SCAM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/scam_pkg.sv =====
// Package for the set-associative tag store: widths, codes, lookup result type.
// Depends on nothing; imported by scam_lookup and set_assoc_cache_mru_sim.
`timescale 1ns / 1ps

package scam_pkg;

	localparam int unsigned MAX_SETS_DEF  = 256;
	localparam int unsigned MAX_WAYS_DEF  = 8;
	localparam int unsigned ADDR_BITS_DEF = 64;

	localparam int unsigned TAG_W      = 63;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned CFG_W      = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned OUT_DATA_W = 104;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET_BITS   = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_WAYS_USED  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic hit;
		logic fill;
		logic evict;
	} lk_res_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
		input logic [1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, c} + {{(CNT_W - 1){1'b0}}, n};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/set_assoc_cache_mru_sim.sv =====
// Set-associative tag store with MRU eviction and saturating hit/miss/evict totals.
// An accepted transaction's set row is read into the memory's read register, then its result is
// registered in the output register; a held result stalls the lookup.
// No new item is taken until the read and the write-back of the set row memory are done for the last.
// Reset: config returns to set_bits 4, block_bits 4, ways_used 1; totals clear; then a
// clearing pass over 2**floor(log2(MAX_SETS)) rows (256 by default) holds s_axis_tready low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_assoc_cache_mru_sim #(
	parameter int unsigned MAX_SETS  = scam_pkg::MAX_SETS_DEF,
	parameter int unsigned MAX_WAYS  = scam_pkg::MAX_WAYS_DEF,
	parameter int unsigned ADDR_BITS = scam_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [scam_pkg::ADDR_W-1:0]       s_axis_tdata,   // addr[63:0]
	input  logic [0:0]                        s_axis_tuser,   // req_type[0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// outcome[1:0], modify_hit[2], hit_total[34:3], miss_total[66:35],
	// eviction_total[98:67], zero[103:99]
	output logic [scam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [scam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scam_pkg::CFG_W-1:0]        cfg_data
);

	import scam_pkg::*;

	localparam int unsigned MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
	localparam int unsigned ROW_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int unsigned NUM_ROWS     = 1 << MAX_SET_BITS;
	localparam int unsigned WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned WCNT_W       = $clog2(MAX_WAYS + 1);
	localparam int unsigned TAGS_W       = MAX_WAYS * TAG_W;
	localparam int unsigned ROW_DW       = WAY_W + MAX_WAYS + TAGS_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
		((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [4:0] SB_MAX = 5'(MAX_SET_BITS);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic [3:0]        set_bits_q;
	logic [5:0]        block_bits_q;
	logic [3:0]        ways_used_q;
	logic [CNT_W-1:0]  hit_q;
	logic [CNT_W-1:0]  miss_q;
	logic [CNT_W-1:0]  evict_q;

	logic [ROW_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              mod_s1;

	logic              acc;
	logic              fire;
	logic [ADDR_W-1:0] a;
	logic [4:0]        sb;
	logic [ADDR_W-1:0] blk_shift;
	logic [ADDR_W-1:0] tag_shift;
	logic [6:0]        tag_amt;
	logic [ROW_W-1:0]  set_mask;
	logic [ROW_W-1:0]  in_set;
	logic [TAG_W-1:0]  in_tag;
	logic [4:0]        wx;
	logic [WCNT_W-1:0] ways_eff;

	logic              ram_we;
	logic [ROW_W-1:0]  ram_waddr;
	logic [ROW_DW-1:0] ram_wdata;
	logic [ROW_DW-1:0] ram_rdata;

	lk_res_t              lk;
	logic [MAX_WAYS-1:0]  new_valid;
	logic [TAGS_W-1:0]    new_tags;
	logic [WAY_W-1:0]     new_recent;
	outcome_t             outcome;
	logic [CNT_W-1:0]     hit_n;
	logic [CNT_W-1:0]     miss_n;
	logic [CNT_W-1:0]     evict_n;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc  = s_axis_tvalid && s_axis_tready;
	assign fire = (state_q == ST_LOOK) && (!m_axis_tvalid || m_axis_tready);

	// address split
	always_comb begin
		a         = s_axis_tdata & ADDR_MASK;
		sb        = ({1'b0, set_bits_q} > SB_MAX) ? SB_MAX : {1'b0, set_bits_q};
		blk_shift = a >> block_bits_q;
		set_mask  = ROW_W'((17'd1 << sb) - 17'd1);
		in_set    = blk_shift[ROW_W-1:0] & set_mask;
		tag_amt   = {2'b00, sb} + {1'b0, block_bits_q};
		tag_shift = (tag_amt >= 7'd64) ? '0 : (a >> tag_amt);
		in_tag    = tag_shift[TAG_W-1:0];
	end

	always_comb begin
		wx = {1'b0, ways_used_q};
		if (wx == 5'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (wx > 5'(MAX_WAYS)) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = wx[WCNT_W-1:0];
		end
	end

	scam_ram #(
		.DATA_W (ROW_DW),
		.ADDR_W (ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (in_set),
		.rdata (ram_rdata)
	);

	scam_lookup #(
		.MAX_WAYS (MAX_WAYS),
		.WAY_W    (WAY_W),
		.WCNT_W   (WCNT_W)
	) u_lookup (
		.valid      (ram_rdata[TAGS_W +: MAX_WAYS]),
		.tags       (ram_rdata[TAGS_W-1:0]),
		.recent     (ram_rdata[ROW_DW-1 -: WAY_W]),
		.tag        (tag_s1),
		.ways       (ways_eff),
		.res        (lk),
		.new_valid  (new_valid),
		.new_tags   (new_tags),
		.new_recent (new_recent)
	);

	assign ram_we    = (state_q == ST_CLEAR) || fire;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_row_q : set_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {new_recent, new_valid, new_tags};

	always_comb begin
		priority if (lk.hit) begin
			outcome = OUT_HIT;
		end else if (lk.fill) begin
			outcome = OUT_FILL;
		end else begin
			outcome = OUT_EVICT;
		end
		hit_n   = sat_add(hit_q, {1'b0, lk.hit} + {1'b0, mod_s1});
		miss_n  = sat_add(miss_q, {1'b0, !lk.hit});
		evict_n = sat_add(evict_q, {1'b0, lk.evict});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_row_q     <= '0;
			set_bits_q    <= 4'd4;
			block_bits_q  <= 6'd4;
			ways_used_q   <= 4'd1;
			hit_q         <= '0;
			miss_q        <= '0;
			evict_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_W'(1);
					if (clr_row_q == ROW_W'(NUM_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
					REG_BLOCK_BITS: block_bits_q <= cfg_data[5:0];
					REG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
					default: begin
					end
				endcase
			end

			if (fire) begin
				hit_q         <= hit_n;
				miss_q        <= miss_n;
				evict_q       <= evict_n;
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// hold the transaction payload and register the result
	always_ff @(posedge clk) begin
		if (acc) begin
			set_s1 <= in_set;
			tag_s1 <= in_tag;
			mod_s1 <= s_axis_tuser[0];
		end
		if (fire) begin
			m_axis_tdata <= {5'd0, evict_n, miss_n, hit_n, mod_s1, outcome};
		end
	end

	`SCAM_ASSERT(a_lk_onehot, clk, arst_n,
		(state_q == ST_LOOK) |-> $onehot({lk.hit, lk.fill, lk.evict}),
		"lookup result not one-hot")
	`SCAM_ASSERT(a_fire_out, clk, arst_n,
		fire |=> (m_axis_tvalid && (m_axis_tdata[2] == $past(mod_s1))),
		"result not presented after lookup")
	`SCAM_ASSERT(a_cnt_mono, clk, arst_n,
		fire |=> ((hit_q >= $past(hit_q)) && (miss_q >= $past(miss_q))
			&& (evict_q >= $past(evict_q))),
		"total decreased")
	`SCAM_ASSERT(a_acc_busy, clk, arst_n,
		acc |=> ((state_q == ST_LOOK) && !s_axis_tready),
		"accepted item not in lookup")
	`SCAM_ASSERT_NEVER(a_no_out_clear, clk, arst_n,
		m_axis_tvalid && (state_q == ST_CLEAR),
		"result valid during clearing pass")

endmodule

// ===== hw/rtl/scam_ram.sv =====
// Set row memory: one write port, one read port with registered read data.
// Depends on nothing; instantiated by set_assoc_cache_mru_sim.
`timescale 1ns / 1ps

module scam_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned ADDR_W = 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/scam_lookup.sv =====
// Set lookup: tag compare, empty-way search, victim choice and updated row.
// Depends on scam_pkg; instantiated by set_assoc_cache_mru_sim.
`timescale 1ns / 1ps

module scam_lookup #(
	parameter int unsigned MAX_WAYS = 8,
	parameter int unsigned WAY_W    = 3,
	parameter int unsigned WCNT_W   = 4
) (
	input  logic [MAX_WAYS-1:0]                 valid,
	input  logic [MAX_WAYS*scam_pkg::TAG_W-1:0] tags,
	input  logic [WAY_W-1:0]                    recent,
	input  logic [scam_pkg::TAG_W-1:0]          tag,
	input  logic [WCNT_W-1:0]                   ways,
	output scam_pkg::lk_res_t                   res,
	output logic [MAX_WAYS-1:0]                 new_valid,
	output logic [MAX_WAYS*scam_pkg::TAG_W-1:0] new_tags,
	output logic [WAY_W-1:0]                    new_recent
);

	import scam_pkg::*;

	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] empty;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    fill_way;
	logic [WAY_W-1:0]    victim;
	logic [WAY_W-1:0]    way;

	always_comb begin
		match    = '0;
		empty    = '0;
		hit_way  = '0;
		fill_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			match[w] = valid[w] && (tags[w*TAG_W +: TAG_W] == tag) && (WCNT_W'(w) < ways);
			empty[w] = !valid[w] && (WCNT_W'(w) < ways);
		end
		// lowest-numbered way wins
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (empty[w]) begin
				fill_way = WAY_W'(w);
			end
		end
		victim = (WCNT_W'(recent) < ways) ? recent : '0;

		res.hit   = |match;
		res.fill  = !(|match) && (|empty);
		res.evict = !(|match) && !(|empty);

		priority if (res.hit) begin
			way = hit_way;
		end else if (res.fill) begin
			way = fill_way;
		end else begin
			way = victim;
		end

		new_valid  = valid;
		new_tags   = tags;
		new_recent = way;
		if (!res.hit) begin
			new_valid[way]                 = 1'b1;
			new_tags[way*TAG_W +: TAG_W]   = tag;
		end
	end

endmodule

// ===== tb/set_assoc_cache_mru_sim_tb.sv =====
// Self-checking testbench for set_assoc_cache_mru_sim: streams accesses, keeps its own
// MRU tag store prediction and compares every result transaction field by field.
// Depends on scam_pkg and the set_assoc_cache_mru_sim RTL.
`timescale 1ns / 1ps

module set_assoc_cache_mru_sim_tb;
	import scam_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_LIMIT   = 5000;
	localparam int MAX_WAIT     = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int SETS         = 256;
	localparam int WAYS         = 8;
	localparam int SET_BITS_MAX = 8;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 170;
	localparam int TAG_POOL     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam bit REQ_SINGLE = 1'b0;
	localparam bit REQ_MODIFY = 1'b1;

	typedef struct {
		outcome_t         outcome;
		logic             modify_hit;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evicts;
	} access_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [ADDR_W-1:0]     s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	// predicted tag store
	bit               line_valid_m [SETS][WAYS];
	logic [TAG_W-1:0] line_tag_m [SETS][WAYS];
	int unsigned      recent_way_m [SETS];
	bit [CNT_W-1:0]   hit_cnt_m;
	bit [CNT_W-1:0]   miss_cnt_m;
	bit [CNT_W-1:0]   evict_cnt_m;
	bit [3:0]         set_bits_m = 4'd4;
	bit [5:0]         block_bits_m = 6'd4;
	bit [3:0]         ways_m = 4'd1;

	access_result_t expected_results[$];
	int             mismatches = 0;
	int             idle_cycles = 0;
	int             tx_gap_max = MAX_WAIT;
	int             rx_gap_max = MAX_WAIT;
	int             rx_hold = 0;

	set_assoc_cache_mru_sim DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic int unsigned eff_set_bits();
		return (set_bits_m > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_m;
	endfunction

	function automatic int unsigned eff_ways();
		if (ways_m == 0)
			return 1;
		if (ways_m > WAYS)
			return WAYS;
		return ways_m;
	endfunction

	function automatic logic [63:0] shift_down(logic [63:0] v, int unsigned n);
		return (n >= 64) ? 64'd0 : (v >> n);
	endfunction

	function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic outcome_t tag_store_access(logic [ADDR_W-1:0] addr);
		int unsigned      sb;
		int unsigned      ways;
		int unsigned      set_idx;
		int unsigned      victim;
		logic [63:0]      tag_wide;
		logic [TAG_W-1:0] tag;
		sb = eff_set_bits();
		ways = eff_ways();
		set_idx = int'(shift_down(addr, block_bits_m) & ((64'd1 << sb) - 64'd1));
		tag_wide = shift_down(addr, sb + block_bits_m);
		tag = tag_wide[TAG_W-1:0];
		for (int w = 0; w < ways; w++) begin
			if (line_valid_m[set_idx][w] && line_tag_m[set_idx][w] == tag) begin
				hit_cnt_m = sat_inc(hit_cnt_m);
				recent_way_m[set_idx] = w;
				return OUT_HIT;
			end
		end
		miss_cnt_m = sat_inc(miss_cnt_m);
		for (int w = 0; w < ways; w++) begin
			if (!line_valid_m[set_idx][w]) begin
				line_valid_m[set_idx][w] = 1'b1;
				line_tag_m[set_idx][w] = tag;
				recent_way_m[set_idx] = w;
				return OUT_FILL;
			end
		end
		evict_cnt_m = sat_inc(evict_cnt_m);
		victim = recent_way_m[set_idx];
		// stale recent way after ways shrink
		if (victim >= ways)
			victim = 0;
		line_tag_m[set_idx][victim] = tag;
		recent_way_m[set_idx] = victim;
		return OUT_EVICT;
	endfunction

	function automatic access_result_t predict_access(bit req, logic [ADDR_W-1:0] addr);
		access_result_t r;
		r.outcome = tag_store_access(addr);
		r.modify_hit = 1'b0;
		if (req == REQ_MODIFY)
			r.modify_hit = (tag_store_access(addr) == OUT_HIT);
		r.hits = hit_cnt_m;
		r.misses = miss_cnt_m;
		r.evicts = evict_cnt_m;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] build_addr(logic [63:0] tag, logic [63:0] set_idx,
		logic [63:0] offset);
		logic [191:0] wide;
		int unsigned  sb;
		sb = eff_set_bits();
		wide = ({128'd0, tag} << (sb + block_bits_m))
			| ({128'd0, set_idx & ((64'd1 << sb) - 64'd1)} << block_bits_m)
			| ({128'd0, offset} & ((192'd1 << block_bits_m) - 192'd1));
		return wide[ADDR_W-1:0];
	endfunction

	task automatic send_access(bit req, logic [ADDR_W-1:0] addr);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = addr;
		s_axis_tuser = req;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_access(req, addr));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			REG_SET_BITS: set_bits_m = value[3:0];
			REG_BLOCK_BITS: block_bits_m = value;
			REG_WAYS_USED: ways_m = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(int sb, int bb, int ways);
		drain_results();
		write_reg(REG_SET_BITS, {2'($urandom_range(0, 3)), 4'(sb)});
		write_reg(REG_BLOCK_BITS, 6'(bb));
		write_reg(REG_WAYS_USED, {2'($urandom_range(0, 3)), 4'(ways)});
	endtask

	task automatic test_default_config();
		send_access(REQ_SINGLE, 64'h0);
		send_access(REQ_SINGLE, 64'h0F);
		send_access(REQ_SINGLE, 64'h100);
		send_access(REQ_MODIFY, 64'h200);
		send_access(REQ_MODIFY, 64'h200);
		send_access(REQ_MODIFY, '1);
	endtask

	task automatic test_register_extremes();
		drain_results();
		write_reg(REG_UNUSED, '1);
		send_access(REQ_SINGLE, 64'h100);
		set_config(15, 63, 15);
		send_access(REQ_SINGLE, 64'h8000_0000_0000_0000);
		send_access(REQ_MODIFY, 64'h0);
		send_access(REQ_SINGLE, '1);
		set_config(SET_BITS_MAX, 0, 0);
		send_access(REQ_SINGLE, 64'h12);
		send_access(REQ_SINGLE, 64'h112);
		send_access(REQ_MODIFY, 64'h12);
	endtask

	task automatic test_stale_recent_way();
		set_config(0, 1, WAYS);
		for (int t = 0; t < WAYS; t++)
			send_access(REQ_SINGLE, build_addr(64'h40 + t, 0, 0));
		set_config(0, 1, 2);
		send_access(REQ_SINGLE, build_addr(64'h99, 0, 0));
		send_access(REQ_MODIFY, build_addr(64'h41, 0, 0));
	endtask

	task automatic test_random_traffic();
		logic [63:0]        tag_pool [TAG_POOL];
		logic [ADDR_W-1:0]  addr;
		logic [63:0]        set_pick;
		int unsigned        pool_size;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(0, 1, 1);
				1: set_config(SET_BITS_MAX, 32, WAYS);
				2: set_config(15, 63, 15);
				default: set_config($urandom_range(0, 9),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10),
					$urandom_range(0, 10));
			endcase
			tx_gap_max = (p % 3 == 2) ? 0 : MAX_WAIT;
			rx_gap_max = (p % 4 == 3) ? 0 : MAX_WAIT;
			for (int i = 0; i < TAG_POOL; i++)
				tag_pool[i] = {$urandom, $urandom};
			pool_size = eff_ways() + 3;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				set_pick = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
					: 64'($urandom_range(0, 3));
				if ($urandom_range(0, 6) == 0)
					addr = {$urandom, $urandom};
				else
					addr = build_addr(tag_pool[$urandom_range(0, pool_size - 1)], set_pick,
						{$urandom, $urandom});
				send_access(1'($urandom_range(0, 1)), addr);
			end
		end
		tx_gap_max = MAX_WAIT;
		rx_gap_max = MAX_WAIT;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready = 1'b0;
				rx_hold--;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rx_hold = $urandom_range(0, rx_gap_max);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transaction: data %h", m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[1:0] !== want.outcome || m_axis_tdata[2] !== want.modify_hit
					|| m_axis_tdata[34:3] !== want.hits || m_axis_tdata[66:35] !== want.misses
					|| m_axis_tdata[98:67] !== want.evicts || m_axis_tdata[103:99] !== 5'd0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected outcome %0d modify_hit %0d hits %0d misses %0d evictions %0d; got outcome %0d modify_hit %0d hits %0d misses %0d evictions %0d pad %h",
							want.outcome, want.modify_hit, want.hits, want.misses, want.evicts,
							m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[34:3],
							m_axis_tdata[66:35], m_axis_tdata[98:67], m_axis_tdata[103:99]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** set_assoc_cache_mru_sim: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SET_BITS;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_config();
		test_register_extremes();
		test_stale_recent_way();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** set_assoc_cache_mru_sim: PASSED **");
		else
			$display("** set_assoc_cache_mru_sim: FAILED **");
		$finish;
	end

endmodule
